### design/tpe_pkg.sv
// Package for the tracking payload encoder: field widths, scaling constants,
// and the report and result types that the top level and its coding units share.
// It depends on nothing else.
`default_nettype none
package tpe_pkg;

    localparam int LAT_W     = 32;
    localparam int LON_W     = 33;
    localparam int ALT_W     = 16;
    localparam int SPEED_W   = 16;
    localparam int CLIMB_W   = 16;
    localparam int TRACK_W   = 15;
    localparam int KIND_W    = 3;
    localparam int CODE_W    = 24;
    localparam int COORD_FRAC_W = 24;

    localparam int LAT_MULT_W = 17;
    localparam int LON_MULT_W = 16;
    localparam logic [LAT_MULT_W-1:0] LAT_MULT = 17'd93206;
    localparam logic [LON_MULT_W-1:0] LON_MULT = 16'd46603;

    localparam logic [12:0] ALT_MAX        = 13'd8190;
    localparam logic [12:0] ALT_DIRECT_MAX = 13'd2047;
    localparam logic [9:0]  SPEED_MAX      = 10'd635;
    localparam logic [9:0]  SEVEN_BIT_MAX  = 10'd127;
    localparam logic [8:0]  CLIMB_MAX      = 9'd315;
    localparam logic [8:0]  CLIMB_DIRECT_MAX = 9'd63;

    // Division by five as a multiply by 205 and a shift by 10, exact below 1024.
    localparam logic [7:0] DIV5_RECIP = 8'd205;
    localparam int         DIV5_SHIFT = 10;

    // Heading is (track + 45) / 90; division by 90 is a multiply by 23302
    // and a shift by 21, exact below 23040.
    localparam logic [15:0] HEAD_ROUND = 16'd45;
    localparam logic [15:0] HEAD_LIMIT = 16'd23040;
    localparam logic [14:0] HEAD_RECIP = 15'd23302;
    localparam int          HEAD_SHIFT = 21;
    localparam logic [7:0]  HEAD_MAX   = 8'd255;

    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic [KIND_W-1:0]         craft_kind;
        logic                      hidden_flag;
        logic [TRACK_W-1:0]        track_angle;
        logic signed [CLIMB_W-1:0] vert_speed;
        logic [SPEED_W-1:0]        ground_speed;
        logic signed [ALT_W-1:0]   alt_metres;
        logic signed [LON_W-1:0]   lon_deg_fix;
        logic signed [LAT_W-1:0]   lat_deg_fix;
    } report_t;

    typedef struct packed {
        logic [15:0] alt_word;
        logic [7:0]  speed_code;
        logic [7:0]  climb_code;
        logic [7:0]  heading_code;
    } motion_t;

    typedef struct packed {
        logic [7:0]        heading_code;
        logic [7:0]        climb_code;
        logic [7:0]        speed_code;
        logic [15:0]       alt_word;
        logic [CODE_W-1:0] lon_code;
        logic [CODE_W-1:0] lat_code;
    } result_t;

endpackage
`default_nettype wire

### design/tracking_payload_encoder.sv
// Tracking payload encoder top level: input register, coding logic, result register.
// Uses tpe_pkg, tpe_coord and tpe_motion.
//
// One position report enters on the s_ channel as a request: s_tdata carries the
// coordinates, altitude, speed, climb and course; s_tuser carries the hidden flag
// and the aircraft type. One encoded result leaves on the m_ channel per report.
// A report accepted at a clock edge is taken into the input register, coded
// from there, and shows on m_tvalid/m_tdata once it moves into the result
// register, which it does when that register is empty or the receiver is ready.
// Throughput is one report per cycle while the receiver is ready: the input
// register, the coding logic and the result register form a two-stage pipeline.
// When the receiver stalls, the result holds on m_tdata, the waiting report
// stays in the input register, and s_tready falls once both stages are full;
// one more report is taken while a result waits.
// The longest path is the latitude and longitude constant multiply with its
// rounding add. A synchronous active-low reset empties both stages and holds
// s_tready low; no result is shown and the first report may be offered in the
// cycle after reset.
// There is no configuration and no state between reports.
`default_nettype none
module tracking_payload_encoder
    import tpe_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // lat_deg_fix[31:0], lon_deg_fix[64:32], alt_metres[80:65], ground_speed[96:81],
    // vert_speed[112:97], track_angle[127:113]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // hidden_flag[0], craft_kind[3:1]
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // lat_code[23:0], lon_code[47:24], alt_word[63:48], speed_code[71:64],
    // climb_code[79:72], heading_code[87:80]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic    in_valid_reg;
    logic    in_valid_next;
    report_t report_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;
    motion_t motion;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            report_reg <= report_t'({s_tuser[3:1], s_tuser[0], s_tdata});
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    tpe_coord #(
        .IN_W   (LAT_W),
        .MULT_W (LAT_MULT_W),
        .MULT   (LAT_MULT)
    ) u_lat (
        .coord (report_reg.lat_deg_fix),
        .code  (result_next.lat_code)
    );

    tpe_coord #(
        .IN_W   (LON_W),
        .MULT_W (LON_MULT_W),
        .MULT   (LON_MULT)
    ) u_lon (
        .coord (report_reg.lon_deg_fix),
        .code  (result_next.lon_code)
    );

    tpe_motion u_motion (
        .report (report_reg),
        .motion (motion)
    );

    assign result_next.alt_word     = motion.alt_word;
    assign result_next.speed_code   = motion.speed_code;
    assign result_next.climb_code   = motion.climb_code;
    assign result_next.heading_code = motion.heading_code;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

`ifndef ASSERT_OFF
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("request taken while both stages are full and stalled");

    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted request did not reach the input register");

    a_alt_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[59] |-> m_tdata[58:48] >= 11'd512)
        else $error("scaled altitude below its smallest value");

    a_speed_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[71] |-> m_tdata[70:64] >= 7'd26)
        else $error("scaled speed below its smallest value");

    a_climb_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[79] |-> m_tdata[78:72] != 7'h40)
        else $error("unscaled climb out of its range");
`endif

endmodule
`default_nettype wire

### design/tpe_coord.sv
// Coordinate coder: one constant multiply, rounding half away from zero,
// and the low bits of the integer part. Uses tpe_pkg.
`default_nettype none
module tpe_coord
    import tpe_pkg::*;
#(
    parameter int IN_W   = LAT_W,
    parameter int MULT_W = LAT_MULT_W,
    parameter logic [MULT_W-1:0] MULT = LAT_MULT
) (
    input  wire logic signed [IN_W-1:0] coord,
    output logic [CODE_W-1:0]           code
);

    localparam int P_W = IN_W + MULT_W + 1;

    logic signed [P_W-1:0] product;
    logic signed [P_W-1:0] rounded;

    // Negative values round half away from zero by adding one less than half.
    always_comb begin
        product = $signed({{(P_W-IN_W){coord[IN_W-1]}}, coord})
                * $signed({{(P_W-MULT_W){1'b0}}, MULT});
        rounded = product + P_W'(64'd1 << (COORD_FRAC_W - 1)) - P_W'(coord[IN_W-1]);
        code    = rounded[CODE_W+COORD_FRAC_W-1:COORD_FRAC_W];
    end

endmodule
`default_nettype wire

### design/tpe_motion.sv
// Altitude, speed, climb and heading coders of the tracking payload.
// Pure combinational logic; uses tpe_pkg.
`default_nettype none
module tpe_motion
    import tpe_pkg::*;
(
    input  wire report_t report,
    output motion_t      motion
);

    logic [12:0] alt_clamp;
    logic [13:0] alt_sum;
    logic [11:0] alt_q;
    logic        alt_scale;
    logic [10:0] alt_bits;

    logic [13:0] spd_round;
    logic [9:0]  spd_clamp;
    logic [9:0]  spd_plus;
    logic [17:0] spd_prod;
    logic [6:0]  spd_q;

    logic        vneg;
    logic [16:0] vmag;
    logic [20:0] vmag10;
    logic [12:0] cmag;
    logic [8:0]  cclamp;
    logic [8:0]  cplus;
    logic [16:0] cprod;
    logic [6:0]  cq;
    logic [6:0]  cbits;

    logic [15:0] hsum;
    logic [29:0] hprod;
    logic [7:0]  heading;

    always_comb begin
        if (report.alt_metres[ALT_W-1]) begin
            alt_clamp = '0;
        end else if (report.alt_metres[ALT_W-2:0] > 15'(ALT_MAX)) begin
            alt_clamp = ALT_MAX;
        end else begin
            alt_clamp = report.alt_metres[12:0];
        end
        alt_sum   = {1'b0, alt_clamp} + 14'd2;
        alt_q     = alt_sum[13:2];
        alt_scale = alt_clamp > ALT_DIRECT_MAX;
        if (!alt_scale) begin
            alt_bits = alt_clamp[10:0];
        end else if (alt_q > 12'(ALT_DIRECT_MAX)) begin
            alt_bits = ALT_DIRECT_MAX[10:0];
        end else begin
            alt_bits = alt_q[10:0];
        end
        motion.alt_word = {~report.hidden_flag, report.craft_kind, alt_scale, alt_bits};

        spd_round = 14'(({1'b0, report.ground_speed} + 17'd4) >> 3);
        spd_clamp = (spd_round > 14'(SPEED_MAX)) ? SPEED_MAX : spd_round[9:0];
        spd_plus  = spd_clamp + 10'd2;
        spd_prod  = 18'(spd_plus) * 18'(DIV5_RECIP);
        spd_q     = spd_prod[DIV5_SHIFT+6:DIV5_SHIFT];
        if (spd_clamp > SEVEN_BIT_MAX) begin
            motion.speed_code = {1'b1, spd_q};
        end else begin
            motion.speed_code = {1'b0, spd_clamp[6:0]};
        end

        vneg   = report.vert_speed[CLIMB_W-1];
        vmag   = vneg ? (17'd0 - {report.vert_speed[CLIMB_W-1], report.vert_speed})
                      : {1'b0, report.vert_speed};
        vmag10 = {1'b0, vmag, 3'b000} + {3'b000, vmag, 1'b0} + 21'd128;
        cmag   = vmag10[20:8];
        cclamp = (cmag > 13'(CLIMB_MAX)) ? CLIMB_MAX : cmag[8:0];
        cplus  = cclamp + 9'd2;
        cprod  = 17'(cplus) * 17'(DIV5_RECIP);
        cq     = cprod[DIV5_SHIFT+6:DIV5_SHIFT];
        if (cclamp > CLIMB_DIRECT_MAX) begin
            cbits = vneg ? (7'd0 - cq) : cq;
            motion.climb_code = {1'b1, cbits};
        end else begin
            cbits = vneg ? (7'd0 - cclamp[6:0]) : cclamp[6:0];
            motion.climb_code = {1'b0, cbits};
        end

        hsum  = {1'b0, report.track_angle} + HEAD_ROUND;
        hprod = 30'(hsum[14:0]) * 30'(HEAD_RECIP);
        if (hsum >= HEAD_LIMIT) begin
            heading = HEAD_MAX;
        end else begin
            heading = hprod[HEAD_SHIFT+7:HEAD_SHIFT];
        end
        motion.heading_code = heading;
    end

endmodule
`default_nettype wire
